@@ rtl/overwrite_fifo_with_mean_macros.svh @@
// Assertion macros shared by the overwrite FIFO RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef OVERWRITE_FIFO_WITH_MEAN_MACROS_SVH
`define OVERWRITE_FIFO_WITH_MEAN_MACROS_SVH

// same-cycle implication, masked during reset
`define OFM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("overwrite fifo check failed");

// next-cycle implication, masked during reset
`define OFM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("overwrite fifo check failed");

`endif

@@ rtl/ofm_pkg.sv @@
// Shared types and constants for the overwrite FIFO with running mean.
// No dependencies.
`default_nettype none

package ofm_pkg;

  localparam int HEIGHT_W = 12;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef logic [HEIGHT_W-1:0] height_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic load_out;
  } ofm_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic div_done;
    logic out_free;
  } ofm_sts_t;

endpackage

`default_nettype wire

@@ rtl/ofm_if.sv @@
// Valid/ready channel interfaces for request and response beats.
// Depends on ofm_pkg.
`default_nettype none

interface ofm_in_if import ofm_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    kind;
  height_t height;

  modport source (output valid, output kind, output height, input ready);
  modport sink (input valid, input kind, input height, output ready);
endinterface

interface ofm_out_if import ofm_pkg::*; ();
  logic    valid;
  logic    ready;
  height_t mean_height;
  height_t popped_height;
  logic    was_empty;

  modport source (output valid, output mean_height, output popped_height,
                  output was_empty, input ready);
  modport sink (input valid, input mean_height, input popped_height,
                input was_empty, output ready);
endinterface

`default_nettype wire

@@ rtl/ofm_div.sv @@
// Restoring divider, one quotient bit per cycle, low quotient bits kept.
// Depends on ofm_pkg for nothing; standalone arithmetic unit.
`default_nettype none

module ofm_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 4,
  parameter int Q_W   = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [Q_W-1:0]        quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  assign trial = {rem, num_sh[NUM_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        num_sh <= num;
        rem    <= '0;
        quo    <= '0;
        cnt    <= CNT_W'(NUM_W);
        busy   <= 1'b1;
        done   <= 1'b0;
      end else if (busy) begin
        rem    <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo    <= {quo[Q_W-2:0], ge};
        num_sh <= {num_sh[NUM_W-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
        done   <= cnt == CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ofm_datapath.sv @@
// Queue storage, pointers, running sum, mean divider and response register.
// Depends on ofm_pkg, ofm_if, ofm_div and the assertion macros.
`default_nettype none
`include "overwrite_fifo_with_mean_macros.svh"

module ofm_datapath import ofm_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_kind,
  input  wire height_t  req_height,
  input  wire ofm_cmd_t cmd,
  output ofm_sts_t      sts,
  ofm_out_if.source     rsp
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SUM_W = HEIGHT_W + IDX_W;
  localparam int NUM_W = SUM_W + 1;
  localparam int DEN_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  height_t          mem [SLOTS];
  height_t          rd_data;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] count;
  logic [SUM_W-1:0] sum;
  logic             kind_r;
  height_t          height_r;
  height_t          res_popped;
  logic             res_empty;
  logic             out_valid;

  logic             full;
  logic             empty;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] tail_inc;
  logic [SUM_W-1:0] drop_amt;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  height_t          div_quo;
  logic [IDX_W:0]   gap_raw;
  logic [IDX_W-1:0] gap_wrap;

  assign full     = count == LAST_IDX;
  assign empty    = count == '0;
  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign tail_inc = (tail == LAST_IDX) ? '0 : tail + 1'b1;
  assign drop_amt = full ? SUM_W'(rd_data) : '0;
  assign div_num  = {sum, 1'b0} + NUM_W'(count);
  assign div_den  = {count, 1'b0};

  always_ff @(posedge clk) begin
    rd_data <= mem[head];
    if (cmd.update && kind_r == KIND_PUSH) begin
      mem[tail] <= height_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      sum   <= '0;
    end else if (cmd.update) begin
      if (kind_r == KIND_PUSH) begin
        tail <= tail_inc;
        sum  <= sum - drop_amt + SUM_W'(height_r);
        if (full) begin
          head <= head_inc;
        end else begin
          count <= count + 1'b1;
        end
      end else if (!empty) begin
        head  <= head_inc;
        count <= count - 1'b1;
        sum   <= sum - SUM_W'(rd_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= req_kind;
      height_r <= req_height;
    end
    if (cmd.update) begin
      res_empty  <= (kind_r == KIND_POP) && empty;
      res_popped <= (kind_r == KIND_POP && !empty) ? rd_data : '0;
    end
  end

  ofm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (HEIGHT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.mean_height   <= (kind_r == KIND_PUSH) ? div_quo : '0;
      rsp.popped_height <= res_popped;
      rsp.was_empty     <= res_empty;
    end
  end

  assign rsp.valid = out_valid;

  assign sts.is_pop   = kind_r == KIND_POP;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || rsp.ready;

  assign gap_raw  = {1'b0, head} + {1'b0, count};
  assign gap_wrap = (gap_raw >= (IDX_W + 1)'(SLOTS)) ?
                    IDX_W'(gap_raw - (IDX_W + 1)'(SLOTS)) : gap_raw[IDX_W-1:0];

  `OFM_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= LAST_IDX)
  `OFM_ASSERT_NOW(a_ring_consistent, clk, rst, 1'b1, gap_wrap == tail)
  `OFM_ASSERT_NOW(a_div_on_push, clk, rst, cmd.div_start, kind_r == KIND_PUSH && !empty)
  `OFM_ASSERT_NEXT(a_load_sets_valid, clk, rst, cmd.load_out, out_valid)

endmodule

`default_nettype wire

@@ rtl/ofm_ctrl.sv @@
// Sequencer for the overwrite FIFO: accept, update, divide (pushes only), respond.
// Depends on ofm_pkg.
`default_nettype none

module ofm_ctrl import ofm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire ofm_sts_t sts,
  output ofm_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  state_t state;

  assign req_ready     = state == S_IDLE;
  assign cmd.capture   = req_valid && state == S_IDLE;
  assign cmd.update    = state == S_CHECK;
  assign cmd.div_start = state == S_DIV_START;
  assign cmd.load_out  = state == S_DONE && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= sts.is_pop ? S_DONE : S_DIV_START;
        end
        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (sts.div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/overwrite_fifo_with_mean.sv @@
// Queue of up to SLOTS-1 heights that drops its oldest entry when a push finds it
// full. A push beat answers with the stored heights' mean rounded half up; a pop beat
// answers with the oldest height, or raises was_empty on an empty queue. One beat is
// processed at a time. After its accept, a pop beat updates the queue and loads the
// response register; a push beat updates the queue, then starts the divider and loads
// the response register when the divider is done. The divider produces one quotient
// bit per cycle over the 13 + log2(SLOTS) bit dividend (log2 rounded up). A response
// stalled by the receiver adds its wait. The response register lets the next request
// in while a response waits to be taken.
// Depends on ofm_pkg, ofm_if, ofm_ctrl, ofm_datapath.
`default_nettype none

module overwrite_fifo_with_mean import ofm_pkg::*; #(
  parameter int SLOTS = 8
) (
  input wire logic  clk,
  input wire logic  rst,
  ofm_in_if.sink    req,
  ofm_out_if.source rsp
);

  ofm_cmd_t cmd;
  ofm_sts_t sts;

  ofm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ofm_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .req_kind   (req.kind),
    .req_height (req.height),
    .cmd        (cmd),
    .sts        (sts),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire

@@ verif/tb_overwrite_fifo_with_mean.sv @@
// Self-checking testbench for overwrite_fifo_with_mean: pushes and pops heights under
// random idling and stalls; compares each response with a local model of ring and mean.
// Depends on ofm_pkg, ofm_if and the overwrite_fifo_with_mean RTL.
`timescale 1ns / 100ps

module tb_overwrite_fifo_with_mean;
  import ofm_pkg::*;

  localparam int SLOTS = 8;

  typedef struct {
    height_t mean_height;
    height_t popped_height;
    logic    was_empty;
  } rsp_beat_t;

  logic clk;
  logic rst;

  ofm_in_if  req_if ();
  ofm_out_if rsp_if ();

  overwrite_fifo_with_mean #(.SLOTS(SLOTS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  height_t     ring [SLOTS];
  int unsigned ring_head;
  int unsigned ring_tail;
  int unsigned ring_count;
  int unsigned height_sum;

  rsp_beat_t awaited_rsp [$];

  int send_idle_pct;
  int recv_stall_pct;
  int err_count;
  int checked_count;
  int push_count;
  int drop_count;
  int pop_count;
  int empty_pop_count;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned next_slot(int unsigned i);
    return (i + 1 >= SLOTS) ? 0 : i + 1;
  endfunction

  function automatic height_t take_oldest();
    height_t v;
    v = ring[ring_head];
    ring_head = next_slot(ring_head);
    ring_count--;
    height_sum -= v;
    return v;
  endfunction

  function automatic rsp_beat_t queue_step(logic kind, height_t height);
    rsp_beat_t r;
    r = '{mean_height: '0, popped_height: '0, was_empty: 1'b0};
    if (kind == KIND_PUSH) begin
      push_count++;
      if (ring_count >= SLOTS - 1) begin
        void'(take_oldest());
        drop_count++;
      end
      ring[ring_tail] = height;
      ring_tail = next_slot(ring_tail);
      ring_count++;
      height_sum += height;
      r.mean_height = height_t'((2 * height_sum + ring_count) / (2 * ring_count));
    end else begin
      pop_count++;
      if (ring_count == 0) begin
        r.was_empty = 1'b1;
        empty_pop_count++;
      end else begin
        r.popped_height = take_oldest();
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    rsp_beat_t want;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (awaited_rsp.size() == 0) begin
        $error("response beat with nothing awaited");
        err_count++;
      end else begin
        want = awaited_rsp.pop_front();
        checked_count++;
        if (rsp_if.mean_height !== want.mean_height) begin
          $error("mean_height: expected %0d, got %0d", want.mean_height, rsp_if.mean_height);
          err_count++;
        end
        if (rsp_if.popped_height !== want.popped_height) begin
          $error("popped_height: expected %0d, got %0d", want.popped_height,
                 rsp_if.popped_height);
          err_count++;
        end
        if (rsp_if.was_empty !== want.was_empty) begin
          $error("was_empty: expected %0b, got %0b", want.was_empty, rsp_if.was_empty);
          err_count++;
        end
      end
    end
  end

  task automatic send_beat(logic kind, height_t height);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid  <= 1'b0;
      req_if.kind   <= 1'($urandom);
      req_if.height <= height_t'($urandom);
      @(posedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.kind   <= kind;
    req_if.height <= height;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    awaited_rsp.push_back(queue_step(kind, height));
  endtask

  task automatic wait_all_answered();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic height_t pick_height();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return height_t'($urandom_range(15));
      3:       return height_t'(4095 - $urandom_range(15));
      default: return height_t'($urandom);
    endcase
  endfunction

  task automatic test_pop_empty();
    send_beat(KIND_POP, 12'hfff);
  endtask

  task automatic test_rounding();
    send_beat(KIND_PUSH, 12'd1);
    send_beat(KIND_PUSH, 12'd2);
  endtask

  task automatic test_overflow();
    repeat (5) send_beat(KIND_PUSH, 12'hfff);
    send_beat(KIND_PUSH, 12'd0);
    send_beat(KIND_PUSH, 12'hfff);
    send_beat(KIND_PUSH, 12'hfff);
  endtask

  task automatic test_drain_to_empty();
    repeat (7) send_beat(KIND_POP, 12'h000);
    send_beat(KIND_POP, 12'hfff);
  endtask

  task automatic test_random_traffic(int items, int idle_pct, int stall_pct);
    int sent;
    int run_len;
    int push_pct;
    sent = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < items) begin
      run_len = $urandom_range(4, 24);
      case ($urandom_range(2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (run_len) begin
        if ($urandom_range(99) < push_pct)
          send_beat(KIND_PUSH, pick_height());
        else
          send_beat(KIND_POP, height_t'($urandom));
        sent++;
      end
    end
    wait_all_answered();
  endtask

  initial begin
    rst           <= 1'b1;
    req_if.valid  <= 1'b0;
    req_if.kind   <= KIND_PUSH;
    req_if.height <= '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    err_count       = 0;
    checked_count   = 0;
    push_count      = 0;
    drop_count      = 0;
    pop_count       = 0;
    empty_pop_count = 0;
    ring_head  = 0;
    ring_tail  = 0;
    ring_count = 0;
    height_sum = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_pop_empty();
    test_rounding();
    test_overflow();
    test_drain_to_empty();
    wait_all_answered();

    test_random_traffic(433, 0, 0);
    test_random_traffic(433, 57, 0);
    test_random_traffic(433, 0, 57);
    test_random_traffic(433, 20, 20);

    repeat (40) @(posedge clk);
    if (awaited_rsp.size() != 0) begin
      $error("%0d responses never arrived", awaited_rsp.size());
      err_count++;
    end
    $display("Ran %0d pushes (%0d dropped the oldest height) and %0d pops (%0d on empty),",
             push_count, drop_count, pop_count, empty_pop_count);
    $display("under four idle/stall mixes; %0d response beats compared, %0d mismatches.",
             checked_count, err_count);
    if (err_count == 0)
      $display("tb_overwrite_fifo_with_mean: done, clean");
    else
      $display("tb_overwrite_fifo_with_mean: done, errors");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_overwrite_fifo_with_mean: done, errors");
    $finish;
  end

endmodule

@@ overwrite_fifo_with_mean.f @@
+incdir+rtl
rtl/ofm_pkg.sv
rtl/ofm_if.sv
rtl/ofm_div.sv
rtl/ofm_datapath.sv
rtl/ofm_ctrl.sv
rtl/overwrite_fifo_with_mean.sv
verif/tb_overwrite_fifo_with_mean.sv
